@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define QALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true
`define QALU_ASSERT_NEVER(label, expr, msg) \
  `QALU_ASSERT(label, !(expr), msg)

`endif

@@ design/qalu_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Operation codes, quaternion types and pipeline latencies.
// ----------------------------------------------------------------------------
package qalu_pkg;

  typedef enum logic [1:0] {
    OP_MUL   = 2'd0,
    OP_CONJ  = 2'd1,
    OP_NORM  = 2'd2,
    OP_IDENT = 2'd3
  } op_e;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  localparam int unsigned MulLat  = 3;
  localparam int unsigned SqrtLat = 35;
  localparam int unsigned DivLat  = 34;
  localparam int unsigned RootW   = 33;
  localparam int unsigned QuotW   = 32;

endpackage

@@ design/qalu_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion ALU channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface qalu_in_if;
  logic               valid;
  logic               ready;
  qalu_pkg::op_e      operation;
  logic signed [31:0] a_w;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_w;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;

  modport source (output valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

interface qalu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_w;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;
  logic               zero_norm;

  modport source (output valid, out_w, out_x, out_y, out_z, saturated, zero_norm,
                  input ready);
  modport sink (input valid, out_w, out_x, out_y, out_z, saturated, zero_norm,
                output ready);
endinterface

@@ design/qalu_mul.sv @@
// ----------------------------------------------------------------------------
// Quaternion multiply / conjugate / identity path
// Three stages: sixteen products, four-term sums, round and saturate.
// ----------------------------------------------------------------------------
module qalu_mul #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  qalu_pkg::op_e         op_i,
  input  qalu_pkg::quat_t       a_i,
  input  qalu_pkg::quat_t       b_i,
  output qalu_pkg::op_e         op_o,
  output qalu_pkg::quat_t       res_o,
  output logic                  sat_o
);

  localparam logic signed [65:0] Half = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] MaxV = 66'sd2147483647;
  localparam logic signed [65:0] MinV = -66'sd2147483648;

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > MaxV) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < MinV) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] neg32(input logic signed [31:0] v);
    logic [32:0] r;
    if (v == 32'sh8000_0000) begin
      r = {1'b1, 32'h7fff_ffff};
    end else begin
      r = {1'b0, -v};
    end
    return r;
  endfunction

  function automatic logic signed [65:0] sx(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];

  assign av[0] = a_i.w;
  assign av[1] = a_i.x;
  assign av[2] = a_i.y;
  assign av[3] = a_i.z;
  assign bv[0] = b_i.w;
  assign bv[1] = b_i.x;
  assign bv[2] = b_i.y;
  assign bv[3] = b_i.z;

  // stage 1: products
  logic signed [63:0] p_q [4][4];
  qalu_pkg::op_e      op1_q;
  qalu_pkg::quat_t    a1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_q[i][j] <= av[i] * bv[j];
        end
      end
      op1_q <= op_i;
      a1_q  <= a_i;
    end
  end

  // stage 2: sums
  logic signed [65:0] s_d [4];
  logic signed [65:0] s_q [4];
  qalu_pkg::op_e      op2_q;
  qalu_pkg::quat_t    a2_q;

  always_comb begin
    s_d[0] = sx(p_q[0][0]) - sx(p_q[1][1]) - sx(p_q[2][2]) - sx(p_q[3][3]);
    s_d[1] = sx(p_q[0][1]) + sx(p_q[3][2]) - sx(p_q[2][3]) + sx(p_q[1][0]);
    s_d[2] = sx(p_q[0][2]) + sx(p_q[1][3]) + sx(p_q[2][0]) - sx(p_q[3][1]);
    s_d[3] = sx(p_q[2][1]) - sx(p_q[1][2]) + sx(p_q[0][3]) + sx(p_q[3][0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        s_q[i] <= s_d[i];
      end
      op2_q <= op1_q;
      a2_q  <= a1_q;
    end
  end

  // stage 3: round half up, saturate, select
  logic [32:0]     m_r [4];
  logic [32:0]     cx;
  logic [32:0]     cy;
  logic [32:0]     cz;
  qalu_pkg::quat_t res_d;
  logic            sat_d;
  qalu_pkg::op_e   op3_q;
  qalu_pkg::quat_t res_q;
  logic            sat_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m_r[i] = sat32((s_q[i] + Half) >>> FRAC_BITS);
    end
    cx = neg32(a2_q.x);
    cy = neg32(a2_q.y);
    cz = neg32(a2_q.z);
    case (op2_q)
      qalu_pkg::OP_MUL: begin
        res_d = '{w: m_r[0][31:0], x: m_r[1][31:0], y: m_r[2][31:0], z: m_r[3][31:0]};
        sat_d = m_r[0][32] | m_r[1][32] | m_r[2][32] | m_r[3][32];
      end
      qalu_pkg::OP_CONJ: begin
        res_d = '{w: a2_q.w, x: cx[31:0], y: cy[31:0], z: cz[31:0]};
        sat_d = cx[32] | cy[32] | cz[32];
      end
      default: begin
        res_d = '{w: 32'sd1 <<< FRAC_BITS, x: '0, y: '0, z: '0};
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op3_q <= op2_q;
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign op_o  = op3_q;
  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

@@ design/qalu_sqrt.sv @@
// ----------------------------------------------------------------------------
// Quaternion norm square root
// Squares, sum, then one root bit per stage over 33 stages.
// ----------------------------------------------------------------------------
module qalu_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  qalu_pkg::quat_t               a_i,
  output qalu_pkg::quat_t               a_o,
  output logic [qalu_pkg::RootW-1:0]    root_o,
  output logic                          zero_o
);

  localparam int unsigned RW   = qalu_pkg::RootW;
  localparam int unsigned SW   = 2 * RW;
  localparam int unsigned RemW = RW + 4;

  // stage A: squares
  logic signed [63:0] sq_d [4];
  logic [62:0]        sq_q [4];
  qalu_pkg::quat_t    aa_q;

  always_comb begin
    sq_d[0] = a_i.w * a_i.w;
    sq_d[1] = a_i.x * a_i.x;
    sq_d[2] = a_i.y * a_i.y;
    sq_d[3] = a_i.z * a_i.z;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= sq_d[i][62:0];
      end
      aa_q <= a_i;
    end
  end

  // stage B: sum of squares, then root stages
  logic [SW-1:0]   rest_q [RW+1];
  logic [RemW-1:0] rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  qalu_pkg::quat_t a_q    [RW+1];
  logic            zero_q [RW+1];
  logic [SW-1:0]   sum_d;

  assign sum_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rest_q[0] <= sum_d;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      a_q[0]    <= aa_q;
      zero_q[0] <= (sum_d == '0);
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RemW-1:0] cat;
    logic [RemW-1:0] trial;
    logic            take;

    assign cat   = {rem_q[k][RemW-3:0], rest_q[k][SW-1:SW-2]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign take  = (cat >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rest_q[k+1] <= {rest_q[k][SW-3:0], 2'b00};
        rem_q[k+1]  <= take ? (cat - trial) : cat;
        root_q[k+1] <= {root_q[k][RW-2:0], take};
        a_q[k+1]    <= a_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  assign a_o    = a_q[RW];
  assign root_o = root_q[RW];
  assign zero_o = zero_q[RW];

endmodule

@@ design/qalu_div.sv @@
// ----------------------------------------------------------------------------
// Quaternion normalize divider
// Four lanes of restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qalu_div #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  qalu_pkg::quat_t               a_i,
  input  logic [qalu_pkg::RootW-1:0]    root_i,
  input  logic                          zero_i,
  output qalu_pkg::quat_t               q_o,
  output logic                          zero_o
);

  localparam int unsigned RW = qalu_pkg::RootW;
  localparam int unsigned QW = qalu_pkg::QuotW;
  localparam int unsigned NW = 2 * QW;

  logic signed [31:0] av [4];
  assign av[0] = a_i.w;
  assign av[1] = a_i.x;
  assign av[2] = a_i.y;
  assign av[3] = a_i.z;

  // stage 0: magnitude and rounded numerator
  logic [NW-1:0] num_d [4];
  logic [31:0]   mag_d [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag_d[l] = av[l][31] ? (~av[l] + 32'd1) : av[l];
      num_d[l] = (NW'(mag_d[l]) << FRAC_BITS) + NW'(root_i >> 1);
    end
  end

  logic [RW:0]   rem_q [QW+1][4];
  logic [QW-1:0] low_q [QW+1][4];
  logic [QW-1:0] quo_q [QW+1][4];
  logic          neg_q [QW+1][4];
  logic [RW-1:0] d_q   [QW+1];
  logic          zero_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 4; l++) begin
        rem_q[0][l] <= (RW+1)'(num_d[l][NW-1:QW]);
        low_q[0][l] <= num_d[l][QW-1:0];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= av[l][31];
      end
      d_q[0]    <= root_i;
      zero_q[0] <= zero_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [RW:0] t;
      logic        take;

      assign t    = {rem_q[k][l][RW-1:0], low_q[k][l][QW-1]};
      assign take = (t >= {1'b0, d_q[k]});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1][l] <= take ? (t - {1'b0, d_q[k]}) : t;
          low_q[k+1][l] <= {low_q[k][l][QW-2:0], 1'b0};
          quo_q[k+1][l] <= {quo_q[k][l][QW-2:0], take};
          neg_q[k+1][l] <= neg_q[k][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k+1]    <= d_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // last stage: sign, zero-norm forcing
  logic [31:0]     sq_d [4];
  qalu_pkg::quat_t q_q;
  logic            zo_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (zero_q[QW]) begin
        sq_d[l] = '0;
      end else if (neg_q[QW][l]) begin
        sq_d[l] = ~quo_q[QW][l] + 32'd1;
      end else begin
        sq_d[l] = quo_q[QW][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q  <= '{w: sq_d[0], x: sq_d[1], y: sq_d[2], z: sq_d[3]};
      zo_q <= zero_q[QW];
    end
  end

  assign q_o    = q_q;
  assign zero_o = zo_q;

endmodule

@@ design/quaternion_alu_core.sv @@
// ----------------------------------------------------------------------------
// Quaternion ALU core
// Multiply, conjugate, normalize and identity on Q2.30 quaternions.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_i    | in  | operation, a_w..a_z, b_w..b_z
//  out_o   | out | out_w..out_z, saturated, zero_norm
//
//  One item per cycle while out_o does not stall.
//  Latency is set by the normalize path: 33-stage root, 32-stage divider.
//  All ops share that latency, so results leave in order.
//  A stall on out_o freezes the whole pipeline; in_i.ready drops with it.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_alu_core #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qalu_in_if.sink     in_i,
  qalu_out_if.source  out_o
);

  localparam int unsigned Lat = 1 + qalu_pkg::SqrtLat + qalu_pkg::DivLat + 1;
  localparam int unsigned Dly = qalu_pkg::SqrtLat + qalu_pkg::DivLat - qalu_pkg::MulLat;

  logic adv;
  logic v_q [Lat];

  assign adv      = !v_q[Lat-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_i.valid;
      for (int i = 1; i < Lat; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // input register
  qalu_pkg::op_e   op_q;
  qalu_pkg::quat_t a_q;
  qalu_pkg::quat_t b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q <= in_i.operation;
      a_q  <= '{w: in_i.a_w, x: in_i.a_x, y: in_i.a_y, z: in_i.a_z};
      b_q  <= '{w: in_i.b_w, x: in_i.b_x, y: in_i.b_y, z: in_i.b_z};
    end
  end

  // direct path
  qalu_pkg::op_e   mop;
  qalu_pkg::quat_t mres;
  logic            msat;

  qalu_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (adv),
    .op_i  (op_q),
    .a_i   (a_q),
    .b_i   (b_q),
    .op_o  (mop),
    .res_o (mres),
    .sat_o (msat)
  );

  qalu_pkg::op_e   dop_q  [Dly];
  qalu_pkg::quat_t dres_q [Dly];
  logic            dsat_q [Dly];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dop_q[0]  <= mop;
      dres_q[0] <= mres;
      dsat_q[0] <= msat;
      for (int i = 1; i < Dly; i++) begin
        dop_q[i]  <= dop_q[i-1];
        dres_q[i] <= dres_q[i-1];
        dsat_q[i] <= dsat_q[i-1];
      end
    end
  end

  // normalize path
  qalu_pkg::quat_t              sa;
  logic [qalu_pkg::RootW-1:0]   root;
  logic                         szero;
  qalu_pkg::quat_t              nres;
  logic                         nzero;

  qalu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (a_q),
    .a_o    (sa),
    .root_o (root),
    .zero_o (szero)
  );

  qalu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (sa),
    .root_i (root),
    .zero_i (szero),
    .q_o    (nres),
    .zero_o (nzero)
  );

  // output register
  qalu_pkg::quat_t out_q;
  logic            sat_q;
  logic            zn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dop_q[Dly-1] == qalu_pkg::OP_NORM) begin
        out_q <= nres;
        sat_q <= 1'b0;
        zn_q  <= nzero;
      end else begin
        out_q <= dres_q[Dly-1];
        sat_q <= dsat_q[Dly-1];
        zn_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid     = v_q[Lat-1];
  assign out_o.out_w     = out_q.w;
  assign out_o.out_x     = out_q.x;
  assign out_o.out_y     = out_q.y;
  assign out_o.out_z     = out_q.z;
  assign out_o.saturated = sat_q;
  assign out_o.zero_norm = zn_q;

  `QALU_ASSERT(a_stall_holds, out_o.valid && !out_o.ready |=> out_o.valid, "result lost in stall")
  `QALU_ASSERT(a_ready_full, !in_i.ready |-> out_o.valid, "input blocked with empty output")
  `QALU_ASSERT_NEVER(a_zero_norm, out_o.valid && out_o.zero_norm && (out_o.saturated || out_o.out_w != 0), "zero norm result not cleared")

endmodule

@@ test/quaternion_alu_checker.sv @@
// ----------------------------------------------------------------------------
// Quaternion ALU result checker
// Watches both channels, predicts each result item from the accepted operation
// item and compares it field by field with the result items in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_alu_checker #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qalu_in_if.sink    in_i,
  qalu_out_if.sink   out_o,
  output int         errors_o,
  output int         pending_o,
  output int         results_o
);
  import qalu_pkg::*;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
    logic               zn;
  } quat_res_t;

  quat_res_t expected_q[$];

  function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // round half up: floor((s + half) / 2^F)
  function automatic logic signed [127:0] scale(input logic signed [127:0] s);
    logic signed [127:0] t;
    t = s + (128'sd1 <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] s);
    logic [63:0] r;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      if ((({64'd0, r | (64'd1 << b)}) * ({64'd0, r | (64'd1 << b)})) <= s)
        r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] norm_comp(input logic signed [31:0] c,
                                                   input logic [127:0] r);
    logic [127:0] mag, q;
    mag = (c < 0) ? 128'(-64'(c)) : 128'(c);
    q = ((mag << FRAC_BITS) + (r >> 1)) / r;
    return (c < 0) ? -32'(q) : 32'(q);
  endfunction

  function automatic quat_res_t quat_predict(input op_e op, input quat_t a, input quat_t b);
    quat_res_t r;
    logic signed [127:0] aw, ax, ay, az, bw, bx, by, bz;
    logic [127:0] ssum, root;
    logic sat;
    sat = 1'b0;
    r = '0;
    aw = a.w; ax = a.x; ay = a.y; az = a.z;
    bw = b.w; bx = b.x; by = b.y; bz = b.z;
    case (op)
      OP_MUL: begin
        r.w = clip(scale(aw*bw - ax*bx - ay*by - az*bz), sat);
        r.x = clip(scale(aw*bx + az*by - ay*bz + ax*bw), sat);
        r.y = clip(scale(aw*by + ax*bz + ay*bw - az*bx), sat);
        r.z = clip(scale(ay*bx - ax*by + aw*bz + az*bw), sat);
      end
      OP_CONJ: begin
        r.w = a.w;
        r.x = clip(-ax, sat);
        r.y = clip(-ay, sat);
        r.z = clip(-az, sat);
      end
      OP_NORM: begin
        ssum = aw*aw + ax*ax + ay*ay + az*az;
        if (ssum == 0) begin
          r.zn = 1'b1;
        end else begin
          root = (ssum >= (128'd1 << 64)) ? (128'd1 << 32) : 128'(int_sqrt(ssum));
          r.w = norm_comp(a.w, root);
          r.x = norm_comp(a.x, root);
          r.y = norm_comp(a.y, root);
          r.z = norm_comp(a.z, root);
        end
        sat = 1'b0;
      end
      default: begin
        r.w = 32'sd1 <<< FRAC_BITS;
      end
    endcase
    r.sat = sat;
    return r;
  endfunction

  initial begin
    errors_o = 0;
    results_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    quat_t qa, qb;
    quat_res_t e, g;
    if (rst_ni && in_i.valid && in_i.ready) begin
      qa = '{in_i.a_w, in_i.a_x, in_i.a_y, in_i.a_z};
      qb = '{in_i.b_w, in_i.b_x, in_i.b_y, in_i.b_z};
      expected_q.push_back(quat_predict(in_i.operation, qa, qb));
    end
    if (rst_ni && out_o.valid && out_o.ready) begin
      g = '{out_o.out_w, out_o.out_x, out_o.out_y, out_o.out_z,
            out_o.saturated, out_o.zero_norm};
      results_o++;
      if (expected_q.size() == 0) begin
        errors_o++;
        if (errors_o <= 10) $display("%0t: unexpected result item %h", $realtime, g);
      end else begin
        e = expected_q.pop_front();
        if (g !== e) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: mismatch exp w=%h x=%h y=%h z=%h s=%b n=%b got w=%h x=%h y=%h z=%h s=%b n=%b",
                     $realtime, e.w, e.x, e.y, e.z, e.sat, e.zn,
                     g.w, g.x, g.y, g.z, g.sat, g.zn);
        end
      end
    end
  end
endmodule

@@ test/quaternion_alu_core_tb.sv @@
// ----------------------------------------------------------------------------
// Quaternion ALU core testbench
// Directed corner items for every operation, then random items, all with
// random sender gaps and random receiver stalls; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_alu_core_tb;
  import qalu_pkg::*;

  localparam int unsigned Latency = 71;
  localparam int NumRandom = 1030;

  logic clk_i;
  logic rst_ni;
  int errors, pending, results, sent;

  qalu_in_if  in_ch();
  qalu_out_if out_ch();

  quaternion_alu_core uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source));

  quaternion_alu_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink),
    .out_o(out_ch.sink), .errors_o(errors), .pending_o(pending), .results_o(results));

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 2 ** 20)) - 32'sd524288;
      4: return 32'sd1 <<< 30;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input op_e op, input quat_t a, input quat_t b);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    {in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z} <= a;
    {in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z} <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // receiver stalls, with stretches of none
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 9) < 3) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(negedge clk_i);
      end
      out_ch.ready <= (gap_len() == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL quaternion_alu_core");
    $finish;
  end

  initial begin
    quat_t mx, mn, z, one, r1, r2;
    op_e op;
    sent = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_MUL;
    {in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z} = '0;
    {in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    mx = {4{32'sh7fffffff}};
    mn = {4{32'sh80000000}};
    z = '0;
    one = {32'sd1 <<< 30, 96'd0};
    send_item(OP_MUL, mx, mx);
    send_item(OP_MUL, mn, mn);
    send_item(OP_MUL, mx, mn);
    send_item(OP_MUL, one, {32'sd3, 32'sd5, -32'sd7, 32'sd9});
    send_item(OP_MUL, {32'sd1, 32'sd1, 32'sd1, 32'sd1}, {32'sd1, -32'sd1, 32'sd1, -32'sd1});
    send_item(OP_MUL, {32'sd0, 32'sd1 <<< 29, 64'd0}, {64'd0, 32'sd1 <<< 29, 32'd0});
    send_item(OP_CONJ, mn, mx);
    send_item(OP_CONJ, mx, z);
    send_item(OP_CONJ, {32'sd5, -32'sd1, 32'sd0, 32'sd7}, mn);
    send_item(OP_NORM, z, mx);
    send_item(OP_NORM, mn, z);
    send_item(OP_NORM, mx, z);
    send_item(OP_NORM, {32'sd1, 96'd0}, z);
    send_item(OP_NORM, {96'd0, -32'sd3}, z);
    send_item(OP_NORM, {32'sd3, 32'sd4, 64'd0}, z);
    send_item(OP_NORM, one, z);
    send_item(OP_IDENT, mn, mx);
    send_item(OP_IDENT, z, z);
    for (int i = 0; i < NumRandom; i++) begin
      op = op_e'($urandom_range(0, 3));
      r1 = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      r2 = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      if (op == OP_NORM && $urandom_range(0, 19) == 0) r1 = z;
      send_item(op, r1, r2);
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    $display("Run covered %0d operation items (directed corners and random), %0d results checked.",
             sent, results);
    if (errors == 0 && pending == 0) begin
      $display("PASS quaternion_alu_core");
    end else begin
      $display("FAIL quaternion_alu_core");
    end
    $finish;
  end
endmodule
